// File: hw/rtl/bpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, codes and control types of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  function automatic int flog2(input int v);
    int r;
    r = 0;
    for (int i = 0; i < 30; i++) begin
      if ((1 << (i + 1)) <= v) r = i + 1;
    end
    return r;
  endfunction

  localparam int POOL_PAGES = 256;
  // largest order that fits both the page store and the 8-bit page field
  localparam int PAGE_W     = (flog2(POOL_PAGES) < 8) ? flog2(POOL_PAGES) : 8;
  localparam int DEPTH      = 1 << PAGE_W;
  localparam int ORD_W      = 4;
  localparam int PS_W       = 21;

  localparam logic [ORD_W-1:0] TOP_CAP    = ORD_W'(PAGE_W);
  localparam logic [ORD_W-1:0] TAG_MERGED = 4'hF;

  // request kinds
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_FIND  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_FREED = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_ORIGIN = 2'd0;
  localparam logic [1:0] CFG_PSIZE  = 2'd1;
  localparam logic [1:0] CFG_PORDER = 2'd2;

  // datapath operations
  typedef logic [3:0] bpa_op_t;
  localparam bpa_op_t OP_NOP       = 4'd0;
  localparam bpa_op_t OP_LOAD      = 4'd1;
  localparam bpa_op_t OP_ORD       = 4'd2;
  localparam bpa_op_t OP_SCAN_RD   = 4'd3;
  localparam bpa_op_t OP_SCAN_EV   = 4'd4;
  localparam bpa_op_t OP_SPLIT     = 4'd5;
  localparam bpa_op_t OP_RANGE     = 4'd6;
  localparam bpa_op_t OP_HD_RD     = 4'd7;
  localparam bpa_op_t OP_HD_EV     = 4'd8;
  localparam bpa_op_t OP_BYTES_RD  = 4'd9;
  localparam bpa_op_t OP_BYTES_CAP = 4'd10;
  localparam bpa_op_t OP_MG_RD     = 4'd11;
  localparam bpa_op_t OP_MG_EV     = 4'd12;
  localparam bpa_op_t OP_MG_FIN    = 4'd13;
  localparam bpa_op_t OP_MUL       = 4'd14;
  localparam bpa_op_t OP_OUT       = 4'd15;

  typedef struct packed {
    bpa_op_t    op;
    logic       st_we;
    logic [1:0] st_code;
  } bpa_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       ord_hit;
    logic       ord_last;
    logic       scan_hit;
    logic       scan_last;
    logic       best_any;
    logic       split_done;
    logic       oor;
    logic       div_done;
    logic       hd_found;
    logic       hd_free;
    logic       mg_top;
    logic       mg_ok;
    logic       out_free;
  } bpa_sts_t;

  function automatic logic [ORD_W-1:0] order_sat(input logic [ORD_W-1:0] v);
    return (v > TOP_CAP) ? TOP_CAP : v;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bpa_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa request / result channels
// Valid-ready channels carrying allocator requests and results.
// ----------------------------------------------------------------------------
interface bpa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] req_size;
  logic [31:0] req_addr;
  modport source (output valid, output req_type, output req_size, output req_addr,
                  input ready);
  modport sink   (input valid, input req_type, input req_size, input req_addr,
                  output ready);
endinterface

interface bpa_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] block_addr;
  logic [7:0]  block_page;
  logic [3:0]  block_order;
  logic [31:0] block_bytes;
  modport source (output valid, output status, output block_addr, output block_page,
                  output block_order, output block_bytes, input ready);
  modport sink   (input valid, input status, input block_addr, input block_page,
                  input block_order, input block_bytes, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bpa_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_div
// Restoring divider, one quotient bit per cycle: byte offset to page index.
// ----------------------------------------------------------------------------
module bpa_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [31:0]                dividend,
  input  logic [bpa_pkg::PS_W-1:0]   divisor,
  output logic                       done,
  output logic [bpa_pkg::PAGE_W-1:0] quot
);
  localparam int PW = bpa_pkg::PAGE_W;
  localparam int CW = $clog2(PW + 1);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   rem_r;
  logic [PW-1:0] q_r;
  logic [31:0]   trial;
  logic          ge;

  assign trial = 32'(divisor) << cnt_r;
  assign ge    = rem_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      busy_r <= (cnt_r != '0);
      done_r <= (cnt_r == '0);
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      q_r   <= '0;
      cnt_r <= CW'(PW - 1);
    end else if (busy_r) begin
      if (ge) rem_r <= rem_r - trial;
      q_r   <= (q_r << 1) | PW'(ge);
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

// File: hw/rtl/bpa_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_dpath
// Allocator datapath: config registers, page tag store, byte-size store,
// order search, head lookup, split and merge updates and the result register.
// ----------------------------------------------------------------------------
module bpa_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_idx,
  input  logic [31:0]          cfg_wdata,
  input  logic [1:0]           in_type,
  input  logic [31:0]          in_size,
  input  logic [31:0]          in_addr,
  input  bpa_pkg::bpa_cmd_t    cmd,
  output bpa_pkg::bpa_sts_t    sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [31:0]          out_addr,
  output logic [7:0]           out_page,
  output logic [3:0]           out_order,
  output logic [31:0]          out_bytes
);
  localparam int PW    = bpa_pkg::PAGE_W;
  localparam int DEPTH = bpa_pkg::DEPTH;
  localparam int OW    = bpa_pkg::ORD_W;
  localparam int SW    = bpa_pkg::PS_W;

  // configuration
  logic [31:0]  origin_r;
  logic [SW-1:0] psize_r;
  logic [OW-1:0] top_r;
  logic [SW-1:0] ps_eff;
  logic          reinit;

  assign reinit = cfg_we && (cfg_idx == bpa_pkg::CFG_PORDER);
  assign ps_eff = (psize_r == '0) ? SW'(1) : psize_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      psize_r  <= SW'(4096);
      top_r    <= bpa_pkg::order_sat(4'd8);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bpa_pkg::CFG_ORIGIN: origin_r <= cfg_wdata;
        bpa_pkg::CFG_PSIZE:  psize_r  <= cfg_wdata[SW-1:0];
        bpa_pkg::CFG_PORDER: top_r    <= bpa_pkg::order_sat(cfg_wdata[OW-1:0]);
        default: ;
      endcase
    end
  end

  // request and working registers
  logic [1:0]    type_r;
  logic [31:0]   size_r, addr_r;
  logic          nul_r;
  logic [1:0]    status_r;
  logic [OW-1:0] ord_r;
  logic [31:0]   psk_r;
  logic [PW:0]   scan_p_r;
  logic [OW-1:0] best_r;
  logic [PW-1:0] best_p_r;
  logic [OW-1:0] hd_j_r;
  logic          head_free_r;
  logic [PW-1:0] res_page_r;
  logic [OW-1:0] res_order_r;
  logic [31:0]   res_bytes_r;
  logic [PW-1:0] mg_p_r;
  logic [OW-1:0] mg_odr_r;
  logic [PW+SW-1:0] prod_r;

  // page tag store: {free, order tag}; entries not yet written read as reset
  logic [4:0]       tag_mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [4:0]       rd_data_r;
  logic             rd_vld_r, rd_zero_r;
  logic [PW-1:0]    rd_addr, wr_addr;
  logic [4:0]       wr_data;
  logic             wr_en;

  logic [31:0]   bytes_mem [DEPTH];
  logic [31:0]   bytes_rd_r;
  logic          bw_en;

  logic [4:0]    ent;
  logic          ent_free;
  logic [OW-1:0] ent_tag;

  assign ent      = rd_vld_r ? rd_data_r :
                    (rd_zero_r ? {1'b1, top_r} : {1'b0, bpa_pkg::TAG_MERGED});
  assign ent_free = ent[4];
  assign ent_tag  = ent[OW-1:0];

  // order search
  logic [PW:0]   scan_nxt, scan_end;
  logic          cand_ok;
  logic [PW-1:0] split_off;
  logic          split_done;

  assign scan_nxt   = scan_p_r + ((PW+1)'(1) << ord_r);
  assign scan_end   = (PW+1)'(1) << top_r;
  assign cand_ok    = ent_free && (ent_tag >= ord_r) && (ent_tag < best_r);
  assign split_done = (best_r == ord_r);
  assign split_off  = PW'(1) << (best_r - 4'd1);

  // address to head page
  logic [31:0]   off;
  logic [32:0]   lim;
  logic          oor;
  logic          div_done;
  logic [PW-1:0] q;
  logic [PW-1:0] hd_cand;
  logic          hd_found;

  assign off      = addr_r - origin_r;
  assign lim      = 33'(ps_eff) << top_r;
  assign oor      = (addr_r < origin_r) || ({1'b0, off} >= lim);
  assign hd_cand  = (q >> hd_j_r) << hd_j_r;
  assign hd_found = (ent_tag != bpa_pkg::TAG_MERGED) || (hd_cand == '0);

  bpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == bpa_pkg::OP_RANGE),
    .dividend (off),
    .divisor  (ps_eff),
    .done     (div_done),
    .quot     (q)
  );

  // merge
  logic [PW-1:0] mg_buddy;
  logic          mg_ok, mg_top;

  assign mg_buddy = mg_p_r ^ (PW'(1) << mg_odr_r);
  assign mg_top   = (mg_odr_r >= top_r);
  assign mg_ok    = ent_free && (ent_tag == mg_odr_r);

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (cmd.op)
      bpa_pkg::OP_SCAN_RD: rd_addr = scan_p_r[PW-1:0];
      bpa_pkg::OP_HD_RD:   rd_addr = hd_cand;
      bpa_pkg::OP_MG_RD:   rd_addr = mg_buddy;
      bpa_pkg::OP_SPLIT: begin
        wr_en = 1'b1;
        if (!split_done) begin
          wr_addr = best_p_r + split_off;
          wr_data = {1'b1, best_r - 4'd1};
        end else begin
          wr_addr = best_p_r;
          wr_data = {1'b0, ord_r};
        end
      end
      bpa_pkg::OP_MG_EV: begin
        wr_en   = mg_ok;
        wr_addr = (mg_buddy > mg_p_r) ? mg_buddy : mg_p_r;
        wr_data = {1'b0, bpa_pkg::TAG_MERGED};
      end
      bpa_pkg::OP_MG_FIN: begin
        wr_en   = 1'b1;
        wr_addr = mg_p_r;
        wr_data = {1'b1, mg_odr_r};
      end
      default: ;
    endcase
  end

  assign bw_en = (cmd.op == bpa_pkg::OP_SPLIT) && split_done;

  always_ff @(posedge clk) begin
    if (wr_en) tag_mem[wr_addr] <= wr_data;
    rd_data_r <= tag_mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
    rd_zero_r <= (rd_addr == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || reinit) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (bw_en) bytes_mem[best_p_r] <= size_r;
    bytes_rd_r <= bytes_mem[res_page_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.st_we) status_r <= cmd.st_code;
    unique case (cmd.op)
      bpa_pkg::OP_LOAD: begin
        type_r      <= in_type;
        size_r      <= in_size;
        addr_r      <= in_addr;
        nul_r       <= (in_type == bpa_pkg::REQ_NONE);
        ord_r       <= '0;
        psk_r       <= 32'(ps_eff);
        scan_p_r    <= '0;
        best_r      <= bpa_pkg::TAG_MERGED;
        hd_j_r      <= '0;
        res_page_r  <= '0;
        res_order_r <= '0;
        res_bytes_r <= '0;
        prod_r      <= '0;
      end
      bpa_pkg::OP_ORD: begin
        if (psk_r < size_r) begin
          ord_r <= ord_r + 4'd1;
          psk_r <= psk_r << 1;
        end
      end
      bpa_pkg::OP_SCAN_EV: begin
        if (cand_ok) begin
          best_r   <= ent_tag;
          best_p_r <= scan_p_r[PW-1:0];
        end
        scan_p_r <= scan_nxt;
      end
      bpa_pkg::OP_SPLIT: begin
        if (!split_done) begin
          best_r <= best_r - 4'd1;
        end else begin
          res_page_r  <= best_p_r;
          res_order_r <= ord_r;
          res_bytes_r <= size_r;
        end
      end
      bpa_pkg::OP_HD_EV: begin
        if (hd_found) begin
          res_page_r  <= hd_cand;
          res_order_r <= ent_tag;
          head_free_r <= ent_free;
          mg_p_r      <= hd_cand;
          mg_odr_r    <= ent_tag;
        end else begin
          hd_j_r <= hd_j_r + 4'd1;
        end
      end
      bpa_pkg::OP_BYTES_CAP: res_bytes_r <= head_free_r ? '0 : bytes_rd_r;
      bpa_pkg::OP_MG_EV: begin
        if (mg_ok) begin
          if (mg_buddy < mg_p_r) mg_p_r <= mg_buddy;
          mg_odr_r <= mg_odr_r + 4'd1;
        end
      end
      bpa_pkg::OP_MUL: prod_r <= res_page_r * ps_eff;
      default: ;
    endcase
  end

  // result register
  logic       out_valid_r;
  logic [1:0] out_status_r;
  logic [31:0] out_addr_r, out_bytes_r;
  logic [7:0] out_page_r;
  logic [3:0] out_order_r;
  logic       zero_res;

  assign zero_res = (status_r != bpa_pkg::ST_OK) || nul_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == bpa_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == bpa_pkg::OP_OUT) begin
      out_status_r <= status_r;
      out_addr_r   <= zero_res ? '0 : origin_r + 32'(prod_r);
      out_page_r   <= zero_res ? '0 : 8'(res_page_r);
      out_order_r  <= zero_res ? '0 : res_order_r;
      out_bytes_r  <= zero_res ? '0 : res_bytes_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_addr   = out_addr_r;
  assign out_page   = out_page_r;
  assign out_order  = out_order_r;
  assign out_bytes  = out_bytes_r;

  always_comb begin
    sts            = '0;
    sts.req_type   = type_r;
    sts.ord_hit    = (psk_r >= size_r);
    sts.ord_last   = (ord_r == top_r);
    sts.scan_hit   = ent_free && (ent_tag == ord_r);
    sts.scan_last  = (scan_nxt >= scan_end);
    sts.best_any   = cand_ok || (best_r != bpa_pkg::TAG_MERGED);
    sts.split_done = split_done;
    sts.oor        = oor;
    sts.div_done   = div_done;
    sts.hd_found   = hd_found;
    sts.hd_free    = ent_free;
    sts.mg_top     = mg_top;
    sts.mg_ok      = mg_ok;
    sts.out_free   = !out_valid_r || out_ready;
  end
endmodule
`default_nettype wire

// File: hw/rtl/bpa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer of the allocator: steps each request through its datapath ops.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bpa_pkg::bpa_sts_t sts,
  output bpa_pkg::bpa_cmd_t cmd
);
  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_DISP      = 5'd1;
  localparam logic [4:0] S_ORD       = 5'd2;
  localparam logic [4:0] S_SCAN_RD   = 5'd3;
  localparam logic [4:0] S_SCAN_EV   = 5'd4;
  localparam logic [4:0] S_SPLIT     = 5'd5;
  localparam logic [4:0] S_RANGE     = 5'd6;
  localparam logic [4:0] S_DIV       = 5'd7;
  localparam logic [4:0] S_HD_RD     = 5'd8;
  localparam logic [4:0] S_HD_EV     = 5'd9;
  localparam logic [4:0] S_BYTES_RD  = 5'd10;
  localparam logic [4:0] S_BYTES_CAP = 5'd11;
  localparam logic [4:0] S_MG_RD     = 5'd12;
  localparam logic [4:0] S_MG_EV     = 5'd13;
  localparam logic [4:0] S_MG_FIN    = 5'd14;
  localparam logic [4:0] S_MUL       = 5'd15;
  localparam logic [4:0] S_DONE      = 5'd16;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op    = bpa_pkg::OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op      = bpa_pkg::OP_LOAD;
          cmd.st_we   = 1'b1;
          cmd.st_code = bpa_pkg::ST_OK;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.req_type)
          bpa_pkg::REQ_ALLOC: state_nxt = S_ORD;
          bpa_pkg::REQ_FREE:  state_nxt = S_RANGE;
          bpa_pkg::REQ_FIND:  state_nxt = S_RANGE;
          default:            state_nxt = S_DONE;
        endcase
      end
      S_ORD: begin
        cmd.op = bpa_pkg::OP_ORD;
        if (sts.ord_hit) begin
          state_nxt = S_SCAN_RD;
        end else if (sts.ord_last) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = bpa_pkg::ST_NOMEM;
          state_nxt   = S_DONE;
        end
      end
      S_SCAN_RD: begin
        cmd.op    = bpa_pkg::OP_SCAN_RD;
        state_nxt = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd.op = bpa_pkg::OP_SCAN_EV;
        if (sts.scan_hit || sts.scan_last) begin
          if (sts.best_any) begin
            state_nxt = S_SPLIT;
          end else begin
            cmd.st_we   = 1'b1;
            cmd.st_code = bpa_pkg::ST_NOMEM;
            state_nxt   = S_DONE;
          end
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SPLIT: begin
        cmd.op = bpa_pkg::OP_SPLIT;
        if (sts.split_done) state_nxt = S_MUL;
      end
      S_RANGE: begin
        cmd.op = bpa_pkg::OP_RANGE;
        if (sts.oor) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = bpa_pkg::ST_RANGE;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_HD_RD;
      end
      S_HD_RD: begin
        cmd.op    = bpa_pkg::OP_HD_RD;
        state_nxt = S_HD_EV;
      end
      S_HD_EV: begin
        cmd.op = bpa_pkg::OP_HD_EV;
        if (!sts.hd_found) begin
          state_nxt = S_HD_RD;
        end else if (sts.req_type == bpa_pkg::REQ_FREE && sts.hd_free) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = bpa_pkg::ST_FREED;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_BYTES_RD;
        end
      end
      S_BYTES_RD: begin
        cmd.op    = bpa_pkg::OP_BYTES_RD;
        state_nxt = S_BYTES_CAP;
      end
      S_BYTES_CAP: begin
        cmd.op    = bpa_pkg::OP_BYTES_CAP;
        state_nxt = (sts.req_type == bpa_pkg::REQ_FIND) ? S_MUL : S_MG_RD;
      end
      S_MG_RD: begin
        cmd.op    = bpa_pkg::OP_MG_RD;
        state_nxt = sts.mg_top ? S_MG_FIN : S_MG_EV;
      end
      S_MG_EV: begin
        cmd.op    = bpa_pkg::OP_MG_EV;
        state_nxt = sts.mg_ok ? S_MG_RD : S_MG_FIN;
      end
      S_MG_FIN: begin
        cmd.op    = bpa_pkg::OP_MG_FIN;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = bpa_pkg::OP_MUL;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op    = bpa_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: hw/rtl/buddy_page_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy page allocator: allocate, free with buddy merge, and block lookup.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         contents
//  in_req    in   valid / ready     req_type, req_size, req_addr
//  out_res   out  valid / ready     status, block_addr/page/order/bytes
//  cfg_*     in   cfg_we            cfg_idx, cfg_wdata (no read-back)
//
//  One request at a time. Allocate: order search, then a scan of candidate
//  heads (up to 2^(pool_order - order)), then the split levels. Free/find:
//  range check, divider and head probes, then merge levels for a free; the
//  tag store's single read port sets the pace. A new request is taken while
//  the previous result still waits in the output register. Synchronous
//  reset; no clearing pass, per-page valid bits restore the reset map at once.
// ----------------------------------------------------------------------------
module buddy_page_allocator (
  input  logic        clk,
  input  logic        rst_n,
  bpa_req_if.sink     in_req,
  bpa_res_if.source   out_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);
  bpa_pkg::bpa_cmd_t cmd;
  bpa_pkg::bpa_sts_t sts;
  logic              in_ready;

  assign in_req.ready = in_ready;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpa_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_type    (in_req.req_type),
    .in_size    (in_req.req_size),
    .in_addr    (in_req.req_addr),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_res.valid),
    .out_ready  (out_res.ready),
    .out_status (out_res.status),
    .out_addr   (out_res.block_addr),
    .out_page   (out_res.block_page),
    .out_order  (out_res.block_order),
    .out_bytes  (out_res.block_bytes)
  );

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.status != bpa_pkg::ST_OK |->
      out_res.block_addr == '0 && out_res.block_page == '0 &&
      out_res.block_order == '0 && out_res.block_bytes == '0)
    else $error("error result carries non-zero fields");

  a_one_job: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_ready |=> !in_req.ready)
    else $error("request taken while another is in progress");

  a_order_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> out_res.block_order <= bpa_pkg::TOP_CAP)
    else $error("result order beyond pool");
`endif
endmodule
`default_nettype wire
